>>> design/gscl_pkg.sv
package gscl_pkg;

   localparam int POS_W        = 17;
   localparam int FRAC_BITS    = 16;
   localparam int POSITION_ONE = 65536;
   localparam int COLOR_W      = 8;
   localparam int DIFF_W       = COLOR_W + 1;
   localparam int PROD_W       = POS_W + 1 + DIFF_W;
   localparam int STEP_W       = PROD_W - FRAC_BITS;
   localparam int INDEX_W      = 4;
   localparam int COUNT_W      = 5;
   localparam int COUNT_RESET  = 2;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_ADDR_W-3:0] CSR_STOP_COUNT = '0;

   typedef enum logic [0:0] {
      CMD_WRITE  = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                command;
      logic [INDEX_W-1:0]  stop_index;
      logic [POS_W-1:0]    stop_position;
      logic [COLOR_W-1:0]  stop_red;
      logic [COLOR_W-1:0]  stop_green;
      logic [COLOR_W-1:0]  stop_blue;
      logic signed [31:0]  position;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } stop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_ADDR,
      ST_EDGE_DATA,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_LOAD,
      ST_SETUP,
      ST_DIVIDE,
      ST_BLEND_MUL,
      ST_BLEND_ADD
   } state_type;

endpackage

>>> design/gscl_ram.sv
module gscl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

>>> design/gscl_div.sv
module gscl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [gscl_pkg::POS_W-1:0]    dividend,
   input  logic [gscl_pkg::POS_W-1:0]    divisor,
   output logic                          done,
   output logic [gscl_pkg::FRAC_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(gscl_pkg::FRAC_BITS);
   localparam int REM_W = gscl_pkg::POS_W + 1;

   logic                          active_ff, active_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [gscl_pkg::FRAC_BITS-1:0] q_ff, q_in;
   logic [gscl_pkg::POS_W-1:0]    den_ff, den_in;
   logic [REM_W-1:0]              shifted;
   logic [REM_W-1:0]              den_ext;

   // dividend is below divisor, so each step yields one quotient bit
   always_comb begin
      shifted   = {rem_ff[REM_W-2:0], 1'b0};
      den_ext   = REM_W'(den_ff);
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      den_in    = den_ff;
      if (go) begin
         active_in = 1'b1;
         cnt_in    = '0;
         rem_in    = REM_W'(dividend);
         den_in    = divisor;
      end else if (active_ff) begin
         if (shifted >= den_ext) begin
            rem_in = shifted - den_ext;
            q_in   = {q_ff[gscl_pkg::FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[gscl_pkg::FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(gscl_pkg::FRAC_BITS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

>>> design/gradient_stop_color_lookup.sv
// Gradient stop color lookup.
// Stops are loaded with write words (command = write) into a table of MAX_STOPS
// slots; a slot at or above MAX_STOPS is dropped. A lookup word carries a signed
// 16.16 position and returns one color on rsp_data, marked by rsp_strobe for a
// single cycle. Writes return nothing and do not raise busy.
// A word is taken when start is high and busy is low; busy stays high while a
// lookup is in progress, so the block holds one lookup at a time and a new word
// can be taken in the cycle that shows the result.
// A lookup at or below zero, or at or above one, returns the first or last stop
// in use. Otherwise a binary search of at most ceil(log2(n - 1)) steps, for n
// stops in use, finds the segment; an empty or reversed segment returns its
// lower stop, and a division step runs only when the position lies strictly
// between the two stop positions of the segment.
// Each search step is one table read and one compare; the serial divider,
// one quotient bit per cycle, sets most of the interpolation time.
// stop_count sits at byte address 0 of the csr_ port and reads back.
// Reset idles the block and sets stop_count to 2; the stop table is not cleared
// and must be written before it is read. The receiver cannot stall: a result is
// shown once and busy is already low in that cycle.
module gradient_stop_color_lookup #(
   parameter int MAX_STOPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  gscl_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output gscl_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gscl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gscl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gscl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W = $clog2(MAX_STOPS);
   localparam int STOP_W = $bits(gscl_pkg::stop_type);
   localparam int POS_W = gscl_pkg::POS_W;
   localparam int COLOR_W = gscl_pkg::COLOR_W;
   localparam int STEP_W = gscl_pkg::STEP_W;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   gscl_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    lo_ff, lo_in;
   logic [IDX_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [IDX_W-1:0]    edge_addr_ff, edge_addr_in;
   logic [POS_W-1:0]    raw_ff, raw_in;
   gscl_pkg::stop_type  lo_ent_ff, lo_ent_in;
   gscl_pkg::stop_type  hi_ent_ff, hi_ent_in;
   logic [POS_W-1:0]    frac_ff, frac_in;
   logic signed [gscl_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]          ch_ff, ch_in;
   gscl_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [gscl_pkg::COUNT_W-1:0] stop_count_ff, stop_count_in;

   logic                accept;
   logic                csr_write;
   logic                csr_hit;
   logic [31:0]         count_ext;
   logic [IDX_W-1:0]    last_idx;
   logic [IDX_W:0]      mid_sum;
   logic                below;
   logic                above;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [IDX_W-1:0]    ram_raddr;
   logic [STOP_W-1:0]   ram_wdata;
   logic [STOP_W-1:0]   ram_rdata;
   gscl_pkg::stop_type  rd_ent;
   gscl_pkg::stop_type  wr_ent;

   logic                div_go;
   logic                div_done;
   logic [gscl_pkg::FRAC_BITS-1:0] div_q;
   logic [POS_W-1:0]    div_num;
   logic [POS_W-1:0]    div_den;

   logic [COLOR_W-1:0]  chan_lo;
   logic [COLOR_W-1:0]  chan_hi;
   logic signed [gscl_pkg::DIFF_W-1:0] diff;
   logic signed [POS_W:0] frac_s;
   logic signed [STEP_W-1:0] chan_sum;
   logic [COLOR_W-1:0]  chan_out;

   assign accept     = start && (state_ff == gscl_pkg::ST_IDLE);
   assign busy       = (state_ff != gscl_pkg::ST_IDLE);
   assign csr_hit    = (csr_paddr[gscl_pkg::CSR_ADDR_W-1:2] == gscl_pkg::CSR_STOP_COUNT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? gscl_pkg::CSR_DATA_W'(stop_count_ff) : '0;

   // table write straight from the request word
   always_comb begin
      wr_ent.position = req_data.stop_position;
      wr_ent.red      = req_data.stop_red;
      wr_ent.green    = req_data.stop_green;
      wr_ent.blue     = req_data.stop_blue;
      ram_wdata       = wr_ent;
      ram_waddr       = IDX_W'(req_data.stop_index);
      ram_we          = accept && (req_data.command == gscl_pkg::CMD_WRITE) &&
                        (32'(req_data.stop_index) < 32'(MAX_STOPS));
      rd_ent          = ram_rdata;
   end

   gscl_ram #(
      .WIDTH (STOP_W),
      .DEPTH (MAX_STOPS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   gscl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // clamp the stop count to 2..MAX_STOPS, keep the last index
   always_comb begin
      count_ext = 32'(stop_count_ff);
      if (count_ext < 32'd2) begin
         last_idx = IDX_W'(1);
      end else if (count_ext > 32'(MAX_STOPS)) begin
         last_idx = IDX_W'(MAX_STOPS - 1);
      end else begin
         last_idx = IDX_W'(count_ext - 32'd1);
      end
      below   = req_data.position[31] || (req_data.position == '0);
      above   = |req_data.position[30:gscl_pkg::FRAC_BITS];
      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   end

   always_comb begin
      case (ch_ff)
         CH_RED: begin
            chan_lo = lo_ent_ff.red;
            chan_hi = hi_ent_ff.red;
         end
         CH_GREEN: begin
            chan_lo = lo_ent_ff.green;
            chan_hi = hi_ent_ff.green;
         end
         default: begin
            chan_lo = lo_ent_ff.blue;
            chan_hi = hi_ent_ff.blue;
         end
      endcase
      diff     = $signed({1'b0, chan_hi}) - $signed({1'b0, chan_lo});
      frac_s   = $signed({1'b0, frac_ff});
      // arithmetic shift of the product floors toward minus infinity
      chan_sum = $signed(STEP_W'(chan_lo)) + prod_ff[gscl_pkg::PROD_W-1:gscl_pkg::FRAC_BITS];
      if (chan_sum < 0) begin
         chan_out = '0;
      end else if (chan_sum > $signed(STEP_W'(255))) begin
         chan_out = '1;
      end else begin
         chan_out = chan_sum[COLOR_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      edge_addr_in  = edge_addr_ff;
      raw_in        = raw_ff;
      lo_ent_in     = lo_ent_ff;
      hi_ent_in     = hi_ent_ff;
      frac_in       = frac_ff;
      prod_in       = prod_ff;
      ch_in         = ch_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_strobe_in = 1'b0;
      stop_count_in = stop_count_ff;
      ram_raddr     = edge_addr_ff;
      div_go        = 1'b0;
      div_num       = raw_ff - lo_ent_ff.position;
      div_den       = rd_ent.position - lo_ent_ff.position;

      if (csr_write && csr_hit) begin
         stop_count_in = csr_pwdata[gscl_pkg::COUNT_W-1:0];
      end

      case (state_ff)
         gscl_pkg::ST_IDLE: begin
            if (accept && (req_data.command == gscl_pkg::CMD_LOOKUP)) begin
               raw_in = req_data.position[POS_W-1:0];
               lo_in  = '0;
               hi_in  = last_idx;
               if (below) begin
                  edge_addr_in = '0;
                  state_in     = gscl_pkg::ST_EDGE_ADDR;
               end else if (above) begin
                  edge_addr_in = last_idx;
                  state_in     = gscl_pkg::ST_EDGE_ADDR;
               end else begin
                  state_in = gscl_pkg::ST_SEARCH;
               end
            end
         end
         gscl_pkg::ST_EDGE_ADDR: begin
            ram_raddr = edge_addr_ff;
            state_in  = gscl_pkg::ST_EDGE_DATA;
         end
         gscl_pkg::ST_EDGE_DATA: begin
            rsp_data_in   = '{red: rd_ent.red, green: rd_ent.green, blue: rd_ent.blue};
            rsp_strobe_in = 1'b1;
            state_in      = gscl_pkg::ST_IDLE;
         end
         gscl_pkg::ST_SEARCH: begin
            if ((hi_ff - lo_ff) == IDX_W'(1)) begin
               ram_raddr = lo_ff;
               state_in  = gscl_pkg::ST_LOAD;
            end else begin
               ram_raddr = mid_sum[IDX_W:1];
               mid_in    = mid_sum[IDX_W:1];
               state_in  = gscl_pkg::ST_SEARCH_CMP;
            end
         end
         gscl_pkg::ST_SEARCH_CMP: begin
            if (rd_ent.position < raw_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
            state_in = gscl_pkg::ST_SEARCH;
         end
         gscl_pkg::ST_LOAD: begin
            lo_ent_in = rd_ent;
            ram_raddr = lo_ff + IDX_W'(1);
            state_in  = gscl_pkg::ST_SETUP;
         end
         gscl_pkg::ST_SETUP: begin
            hi_ent_in = rd_ent;
            ch_in     = CH_RED;
            if (rd_ent.position <= lo_ent_ff.position) begin
               // empty or reversed segment: take the lower stop
               rsp_data_in   = '{red: lo_ent_ff.red, green: lo_ent_ff.green,
                                 blue: lo_ent_ff.blue};
               rsp_strobe_in = 1'b1;
               state_in      = gscl_pkg::ST_IDLE;
            end else if (raw_ff <= lo_ent_ff.position) begin
               frac_in  = '0;
               state_in = gscl_pkg::ST_BLEND_MUL;
            end else if (div_num >= div_den) begin
               frac_in  = POS_W'(gscl_pkg::POSITION_ONE);
               state_in = gscl_pkg::ST_BLEND_MUL;
            end else begin
               div_go   = 1'b1;
               state_in = gscl_pkg::ST_DIVIDE;
            end
         end
         gscl_pkg::ST_DIVIDE: begin
            if (div_done) begin
               frac_in  = POS_W'(div_q);
               state_in = gscl_pkg::ST_BLEND_MUL;
            end
         end
         gscl_pkg::ST_BLEND_MUL: begin
            prod_in  = gscl_pkg::PROD_W'(frac_s) * gscl_pkg::PROD_W'(diff);
            state_in = gscl_pkg::ST_BLEND_ADD;
         end
         gscl_pkg::ST_BLEND_ADD: begin
            case (ch_ff)
               CH_RED:   rsp_data_in.red   = chan_out;
               CH_GREEN: rsp_data_in.green = chan_out;
               default:  rsp_data_in.blue  = chan_out;
            endcase
            if (ch_ff == CH_BLUE) begin
               rsp_strobe_in = 1'b1;
               state_in      = gscl_pkg::ST_IDLE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = gscl_pkg::ST_BLEND_MUL;
            end
         end
         default: begin
            state_in = gscl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gscl_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         stop_count_ff <= gscl_pkg::COUNT_W'(gscl_pkg::COUNT_RESET);
         ch_ff         <= CH_RED;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         stop_count_ff <= stop_count_in;
         ch_ff         <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      edge_addr_ff <= edge_addr_in;
      raw_ff       <= raw_in;
      lo_ent_ff    <= lo_ent_in;
      hi_ent_ff    <= hi_ent_in;
      frac_ff      <= frac_in;
      prod_ff      <= prod_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> design/gscl_checker.sv
module gscl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input gscl_pkg::req_type req_data,
   input logic              rsp_strobe
);

   logic take_lookup;
   logic take_write;

   assign take_lookup = start && !busy && (req_data.command == gscl_pkg::CMD_LOOKUP);
   assign take_write  = start && !busy && (req_data.command == gscl_pkg::CMD_WRITE);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      take_lookup |=> (busy && !rsp_strobe))
      else $error("lookup word did not hold the block busy");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      take_write |=> (!busy && !rsp_strobe))
      else $error("stop write produced a result or held the block");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result word without a lookup in progress");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result word shown twice");

endmodule

bind gradient_stop_color_lookup gscl_checker u_gscl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe)
);

>>> test/gscl_color_checker.sv
module gscl_color_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  gscl_pkg::req_type               req_data,
   input  logic                            rsp_strobe,
   input  gscl_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gscl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gscl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [gscl_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                            csr_pready,
   output int                              mismatches,
   output int                              colors_pending,
   output int                              colors_checked,
   output int                              stops_loaded
);

   localparam int MAX_STOPS = 16;
   localparam logic [gscl_pkg::CSR_ADDR_W-1:0] STOP_COUNT_ADDR =
      {gscl_pkg::CSR_STOP_COUNT, 2'b00};

   gscl_pkg::stop_type           stop_table [MAX_STOPS];
   logic [gscl_pkg::COUNT_W-1:0] stop_count;
   gscl_pkg::rsp_type            expected_colors [$];

   initial begin
      mismatches     = 0;
      colors_pending = 0;
      colors_checked = 0;
      stops_loaded   = 0;
   end

   function automatic gscl_pkg::rsp_type stop_color(gscl_pkg::stop_type s);
      gscl_pkg::rsp_type c;
      c.red   = s.red;
      c.green = s.green;
      c.blue  = s.blue;
      return c;
   endfunction

   // floor of frac*diff/one, arithmetic shift rounds toward minus infinity
   function automatic logic [gscl_pkg::COLOR_W-1:0] blend(
      logic [gscl_pkg::COLOR_W-1:0] lo_c,
      logic [gscl_pkg::COLOR_W-1:0] hi_c,
      longint                       frac);
      longint c;
      c = longint'(lo_c) +
          ((frac * (longint'(hi_c) - longint'(lo_c))) >>> gscl_pkg::FRAC_BITS);
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      return c[gscl_pkg::COLOR_W-1:0];
   endfunction

   function automatic gscl_pkg::rsp_type predict_color(logic [31:0] raw);
      int                 n;
      int                 lo;
      int                 hi;
      int                 mid;
      longint             p_lo;
      longint             p_hi;
      longint             frac;
      gscl_pkg::stop_type s_lo;
      gscl_pkg::stop_type s_hi;
      gscl_pkg::rsp_type  c;
      if (stop_count < 2) n = 2;
      else if (stop_count > MAX_STOPS) n = MAX_STOPS;
      else n = int'(stop_count);
      if (raw == 0 || raw[31]) return stop_color(stop_table[0]);
      if (raw >= gscl_pkg::POSITION_ONE) return stop_color(stop_table[n-1]);
      lo = 0;
      hi = n - 1;
      while (hi - lo != 1) begin
         mid = (lo + hi) / 2;
         if (stop_table[mid].position < raw) lo = mid;
         else hi = mid;
      end
      s_lo = stop_table[lo];
      s_hi = stop_table[lo+1];
      p_lo = longint'(s_lo.position);
      p_hi = longint'(s_hi.position);
      // empty or reversed segment keeps the lower color
      if (p_hi <= p_lo) return stop_color(s_lo);
      if (longint'(raw) <= p_lo) frac = 0;
      else frac = (longint'(gscl_pkg::POSITION_ONE) * (longint'(raw) - p_lo)) /
                  (p_hi - p_lo);
      if (frac > gscl_pkg::POSITION_ONE) frac = gscl_pkg::POSITION_ONE;
      c.red   = blend(s_lo.red, s_hi.red, frac);
      c.green = blend(s_lo.green, s_hi.green, frac);
      c.blue  = blend(s_lo.blue, s_hi.blue, frac);
      return c;
   endfunction

   task automatic check_channel(string name, logic [gscl_pkg::COLOR_W-1:0] want,
                                logic [gscl_pkg::COLOR_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      gscl_pkg::rsp_type  want;
      gscl_pkg::stop_type s;
      if (reset) begin
         stop_count = gscl_pkg::COUNT_W'(gscl_pkg::COUNT_RESET);
         expected_colors.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == STOP_COUNT_ADDR) begin
            if (csr_pwrite) begin
               stop_count = csr_pwdata[gscl_pkg::COUNT_W-1:0];
            end else if (csr_prdata !== gscl_pkg::CSR_DATA_W'(stop_count)) begin
               mismatches++;
               $display("%0t: stop_count read mismatch, expected %0d, actual %0d",
                        $time, stop_count, csr_prdata);
            end
         end
         if (rsp_strobe) begin
            if (expected_colors.size() == 0) begin
               mismatches++;
               $display("%0t: color word with none expected, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_colors.pop_front();
               check_channel("red", want.red, rsp_data.red);
               check_channel("green", want.green, rsp_data.green);
               check_channel("blue", want.blue, rsp_data.blue);
               colors_checked++;
            end
         end
         if (start && !busy) begin
            if (req_data.command == gscl_pkg::CMD_LOOKUP) begin
               expected_colors.push_back(predict_color(req_data.position));
            end else begin
               s.position = req_data.stop_position;
               s.red      = req_data.stop_red;
               s.green    = req_data.stop_green;
               s.blue     = req_data.stop_blue;
               stop_table[req_data.stop_index] = s;
               stops_loaded++;
            end
         end
      end
      colors_pending = expected_colors.size();
   end

endmodule

>>> test/gradient_stop_color_lookup_tb.sv
module gradient_stop_color_lookup_tb;

   localparam int MAX_STOPS       = 16;
   localparam int ITEMS           = 1750;
   localparam int LOOKUPS_PER_SET = 140;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam logic [gscl_pkg::CSR_ADDR_W-1:0] STOP_COUNT_ADDR =
      {gscl_pkg::CSR_STOP_COUNT, 2'b00};

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            start       = 1'b0;
   logic                            busy;
   gscl_pkg::req_type               req_data    = '0;
   logic                            rsp_strobe;
   gscl_pkg::rsp_type               rsp_data;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [gscl_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [gscl_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [gscl_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int mismatches;
   int colors_pending;
   int colors_checked;
   int stops_loaded;

   int words_sent   = 0;
   int burst_left   = 0;
   int settings     = 0;
   int idle_cycles  = 0;
   bit steady       = 1'b0;
   int stop_pos_mirror [MAX_STOPS];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gradient_stop_color_lookup DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gscl_color_checker color_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatches     (mismatches),
      .colors_pending (colors_pending),
      .colors_checked (colors_checked),
      .stops_loaded   (stops_loaded)
   );

   // reset, any accepted word, CSR access or returned color restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("gradient_stop_color_lookup verification failed");
         $finish;
      end
   end

   function automatic gscl_pkg::req_type noise_word();
      logic [95:0] bits;
      bits = {$urandom(), $urandom(), $urandom()};
      return bits[$bits(gscl_pkg::req_type)-1:0];
   endfunction

   function automatic logic [gscl_pkg::COLOR_W-1:0] pick_channel();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return gscl_pkg::COLOR_W'($urandom());
      endcase
   endfunction

   task automatic drain();
      start <= 1'b0;
      while (colors_pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic pace();
      int gap;
      if (steady) return;
      burst_left--;
      if (burst_left > 0) return;
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 40) == 0) begin
         drain();
         return;
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) begin
         req_data <= noise_word();
         @(negedge clock);
      end
   endtask

   // call at a falling edge; returns at a falling edge after the word is taken
   task automatic send_word(gscl_pkg::req_type w);
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      words_sent++;
      pace();
   endtask

   task automatic write_stop(int idx, int pos, bit extreme_colors);
      gscl_pkg::req_type w;
      w = noise_word();
      w.command       = gscl_pkg::CMD_WRITE;
      w.stop_index    = idx[gscl_pkg::INDEX_W-1:0];
      w.stop_position = pos[gscl_pkg::POS_W-1:0];
      if (extreme_colors) begin
         w.stop_red   = idx[0] ? '1 : '0;
         w.stop_green = idx[0] ? '0 : '1;
         w.stop_blue  = gscl_pkg::COLOR_W'(idx * 17);
      end else begin
         w.stop_red   = pick_channel();
         w.stop_green = pick_channel();
         w.stop_blue  = pick_channel();
      end
      stop_pos_mirror[idx] = pos;
      send_word(w);
   endtask

   task automatic look_up(logic [31:0] p);
      gscl_pkg::req_type w;
      w = noise_word();
      w.command  = gscl_pkg::CMD_LOOKUP;
      w.position = p;
      send_word(w);
   endtask

   task automatic csr_access(bit write, logic [gscl_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= STOP_COUNT_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_stop_count(logic [gscl_pkg::CSR_DATA_W-1:0] value);
      drain();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
      settings++;
   endtask

   task automatic load_table(int n, bit ordered);
      int pos;
      pos = 0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         if (!ordered)
            pos = $urandom_range(0, gscl_pkg::POSITION_ONE);
         else if (i == 0)
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000) : 0;
         else if ($urandom_range(0, 7) != 0)
            pos += $urandom_range(1, 2 * gscl_pkg::POSITION_ONE / n);
         if (ordered && i == n - 1 && $urandom_range(0, 1) == 1)
            pos = gscl_pkg::POSITION_ONE;
         if (pos > gscl_pkg::POSITION_ONE) pos = gscl_pkg::POSITION_ONE;
         write_stop(i, pos, 1'b0);
      end
   endtask

   task automatic run_lookups(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, MAX_STOPS - 1);
         case ($urandom_range(0, 19))
            0: look_up($urandom());
            1: begin
               case ($urandom_range(0, 6))
                  0: look_up(32'h0000_0000);
                  1: look_up(32'hFFFF_FFFF);
                  2: look_up(32'h8000_0000);
                  3: look_up(32'h7FFF_FFFF);
                  4: look_up(32'h0001_0000);
                  5: look_up(32'h0000_FFFF);
                  default: look_up(32'h0000_0001);
               endcase
            end
            2, 3: look_up(32'(stop_pos_mirror[k] + $urandom_range(0, 2) - 1));
            4: write_stop(k, $urandom_range(0, gscl_pkg::POSITION_ONE), 1'b0);
            default: look_up(32'($urandom_range(1, gscl_pkg::POSITION_ONE - 1)));
         endcase
      end
   endtask

   initial begin
      int count_plan [11];
      int value;
      int in_use;
      count_plan = '{16, 2, 0, 1, 31, 3, 16, 9, 17, 5, 0};
      count_plan[10] = $urandom_range(0, 31);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // fill every slot first: an even ramp with an empty segment, a reversed
      // pair, a first stop above zero and a last stop at one
      steady = 1'b1;
      for (int i = 0; i < MAX_STOPS; i++) begin
         value = i * 4369;
         if (i == 0) value = 300;
         if (i == 3) value = 2 * 4369;
         if (i == 6) value = 20000;
         if (i == MAX_STOPS - 1) value = gscl_pkg::POSITION_ONE;
         write_stop(i, value, 1'b1);
      end
      // two stops in use out of reset
      look_up(32'd30000);
      look_up(32'd100);
      set_stop_count(32'd16);
      look_up(32'h0000_0000);
      look_up(32'hFFFF_FFFF);
      look_up(32'h8000_0000);
      look_up(32'h7FFF_FFFF);
      look_up(32'h0001_0000);
      look_up(32'h0000_FFFF);
      look_up(32'h0000_0001);
      look_up(32'd8738);
      look_up(32'd20500);

      for (int ph = 0; ph < 11; ph++) begin
         value = count_plan[ph];
         // upper data bits are not part of the register
         if ($urandom_range(0, 2) == 0) value = value | ($urandom() & 32'hFFFF_FFE0);
         set_stop_count(value);
         in_use = count_plan[ph] < 2 ? 2 : (count_plan[ph] > MAX_STOPS ? MAX_STOPS
                                                                     : count_plan[ph]);
         steady = (ph % 4 == 3);
         burst_left = $urandom_range(1, 40);
         load_table(in_use, $urandom_range(0, 4) != 0);
         run_lookups(LOOKUPS_PER_SET);
      end

      drain();
      repeat (60) @(negedge clock);
      $display("covered %0d words: %0d stop writes, %0d colors checked, %0d stop_count settings",
               words_sent, stops_loaded, colors_checked, settings);
      $display("tables ordered, duplicated and unordered; positions at, inside and beyond 0..1");
      if (mismatches == 0 && colors_pending == 0)
         $display("gradient_stop_color_lookup verification clean");
      else
         $display("gradient_stop_color_lookup verification failed");
      $finish;
   end

endmodule
